### hw/rtl/mpts_pkg.sv
// ============================================================================
// mpts_pkg
// Shared types, codes and pattern functions for the memory pattern test
// sequencer.
// ============================================================================
package mpts_pkg;

    localparam int OP_W      = 2;
    localparam int DATA_W    = 32;
    localparam int SIZE_W    = 2;
    localparam int ADDR_W    = 26;
    localparam int RES_W     = 2;
    localparam int REGION_W  = 25;
    localparam int INDEX_W   = 27;
    localparam int PASS_W    = 3;

    // Command codes on the command channel.
    localparam logic [OP_W-1:0] OP_START   = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_ACK  = 2'd1;
    localparam logic [OP_W-1:0] OP_RD_DATA = 2'd2;

    // Access size codes; also the index of the width run.
    localparam logic [SIZE_W-1:0] SIZE_32 = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_16 = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_8  = 2'd2;

    // Per-width run result codes.
    localparam logic [RES_W-1:0] RES_NONE = 2'd0;
    localparam logic [RES_W-1:0] RES_PASS = 2'd1;
    localparam logic [RES_W-1:0] RES_FAIL = 2'd2;

    localparam logic [PASS_W-1:0]   LAST_PASS    = 3'd7;
    localparam logic [REGION_W-1:0] REGION_RESET = 25'd4194304;
    localparam logic [REGION_W-1:0] REGION_MAX   = 25'd16777216;

    function automatic logic [DATA_W-1:0] stage_mask(input logic [SIZE_W-1:0] stage);
        logic [DATA_W-1:0] m;
        begin
            unique case (stage)
                SIZE_32: m = 32'hFFFF_FFFF;
                SIZE_16: m = 32'h0000_FFFF;
                default: m = 32'h0000_00FF;
            endcase
            return m;
        end
    endfunction

    function automatic logic [DATA_W-1:0] pattern_value(
        input logic [PASS_W-1:0]  pass,
        input logic [INDEX_W-1:0] idx,
        input logic [SIZE_W-1:0]  stage
    );
        logic [DATA_W-1:0] v;
        begin
            unique case (pass)
                3'd0:    v = idx[0] ? 32'ha5a5_a5a5 : 32'h5a5a_5a5a;
                3'd1:    v = idx[0] ? 32'h3c3c_3c3c : 32'hc3c3_c3c3;
                3'd2:    v = 32'h5555_5555;
                3'd3:    v = 32'haaaa_aaaa;
                3'd4:    v = {{(DATA_W-INDEX_W){1'b0}}, idx};
                3'd5:    v = 32'h3333_3333;
                3'd6:    v = 32'hcccc_cccc;
                default: v = 32'h7777_7777;
            endcase
            return v & stage_mask(stage);
        end
    endfunction

endpackage

### hw/rtl/mpts_cmd_if.sv
// ============================================================================
// mpts_cmd_if
// Command channel of the sequencer: start, write acknowledge and read data.
// ============================================================================
interface mpts_cmd_if import mpts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] read_data;

    modport source (output valid, output op, output read_data, input ready);
    modport sink   (input valid, input op, input read_data, output ready);
endinterface

### hw/rtl/mpts_req_if.sv
// ============================================================================
// mpts_req_if
// Request channel of the sequencer: memory request and run status per word.
// ============================================================================
interface mpts_req_if import mpts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_valid;
    logic              req_write;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] req_addr;
    logic [DATA_W-1:0] req_data;
    logic              done_res;
    logic [RES_W-1:0]  result_word32;
    logic [RES_W-1:0]  result_half16;
    logic [RES_W-1:0]  result_byte8;

    modport source (output valid, output req_valid, output req_write, output req_size,
                    output req_addr, output req_data, output done_res,
                    output result_word32, output result_half16, output result_byte8,
                    input ready);
    modport sink   (input valid, input req_valid, input req_write, input req_size,
                    input req_addr, input req_data, input done_res,
                    input result_word32, input result_half16, input result_byte8,
                    output ready);
endinterface

### hw/rtl/memory_pattern_test_sequencer.sv
// ============================================================================
// memory_pattern_test_sequencer
// Drives a memory port through an eight-pass pattern test at 32, 16 and
// 8-bit access widths and reports pass or fail per width.
// ============================================================================
// Every command word produces exactly one request word, in the cycle after
// it is taken. The sequencing state and the request fields are computed
// combinationally from the command and the state registers, and the request
// is held in an output register; a new command is taken in every cycle in
// which that register is empty or being drained, so the sustained rate is
// one word per cycle. The region size is read live from the configuration
// register and should only be changed while no test is running.
module memory_pattern_test_sequencer
    import mpts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [REGION_W-1:0] cfg_wr_data,
    mpts_cmd_if.sink            cmd,
    mpts_req_if.source          req
);

    logic [REGION_W-1:0] region_reg;
    logic                running_reg, running_next;
    logic [SIZE_W-1:0]   stage_reg, stage_next;
    logic [PASS_W-1:0]   pass_reg, pass_next;
    logic                reading_reg, reading_next;
    logic [INDEX_W-1:0]  idx_reg, idx_next;
    logic [RES_W-1:0]    res32_reg, res32_next;
    logic [RES_W-1:0]    res16_reg, res16_next;
    logic [RES_W-1:0]    res8_reg, res8_next;

    logic                out_valid_reg;
    logic                req_valid_reg, req_write_reg, done_reg;
    logic [SIZE_W-1:0]   req_size_reg;
    logic [ADDR_W-1:0]   req_addr_reg;
    logic [DATA_W-1:0]   req_data_reg;
    logic [RES_W-1:0]    out_res32_reg, out_res16_reg, out_res8_reg;

    logic                cmd_fire;
    logic [REGION_W-1:0] region_eff;
    logic [INDEX_W-1:0]  elem_count;
    logic [INDEX_W-1:0]  idx_inc;
    logic                idx_last;
    logic                mismatch;
    logic                issue_v, issue_w, done_v;
    logic                finish_v, finish_fail;
    logic [INDEX_W+1:0]  addr_full;
    logic [DATA_W-1:0]   data_next;

    assign cmd.ready = !out_valid_reg || req.ready;
    assign cmd_fire  = cmd.valid && cmd.ready;

    // A zero region acts as one word, and sizes beyond the maximum are clamped.
    always_comb
    begin
        if (region_reg == '0)
            region_eff = {{(REGION_W-1){1'b0}}, 1'b1};
        else if (region_reg > REGION_MAX)
            region_eff = REGION_MAX;
        else
            region_eff = region_reg;
    end

    assign elem_count = {{(INDEX_W-REGION_W){1'b0}}, region_eff} << stage_reg;
    assign idx_inc    = idx_reg + {{(INDEX_W-1){1'b0}}, 1'b1};
    assign idx_last   = idx_inc >= elem_count;
    assign mismatch   = (cmd.read_data & stage_mask(stage_reg))
                        != pattern_value(pass_reg, idx_reg, stage_reg);

    always_comb
    begin
        running_next = running_reg;
        stage_next   = stage_reg;
        pass_next    = pass_reg;
        reading_next = reading_reg;
        idx_next     = idx_reg;
        res32_next   = res32_reg;
        res16_next   = res16_reg;
        res8_next    = res8_reg;
        issue_v      = 1'b0;
        issue_w      = 1'b0;
        done_v       = 1'b0;
        finish_v     = 1'b0;
        finish_fail  = 1'b0;

        priority if (cmd.op == OP_START)
        begin
            running_next = 1'b1;
            stage_next   = SIZE_32;
            pass_next    = '0;
            reading_next = 1'b0;
            idx_next     = '0;
            res32_next   = RES_NONE;
            res16_next   = RES_NONE;
            res8_next    = RES_NONE;
            issue_v      = 1'b1;
            issue_w      = 1'b1;
        end
        else if (cmd.op == OP_WR_ACK && running_reg && !reading_reg)
        begin
            issue_v = 1'b1;
            if (idx_last)
            begin
                reading_next = 1'b1;
                idx_next     = '0;
            end
            else
            begin
                idx_next = idx_inc;
                issue_w  = 1'b1;
            end
        end
        else if (cmd.op == OP_RD_DATA && running_reg && reading_reg)
        begin
            if (mismatch)
            begin
                finish_v    = 1'b1;
                finish_fail = 1'b1;
            end
            else if (idx_last)
            begin
                if (pass_reg == LAST_PASS)
                    finish_v = 1'b1;
                else
                begin
                    pass_next    = pass_reg + 3'd1;
                    reading_next = 1'b0;
                    idx_next     = '0;
                    issue_v      = 1'b1;
                    issue_w      = 1'b1;
                end
            end
            else
            begin
                idx_next = idx_inc;
                issue_v  = 1'b1;
            end
        end
        else
        begin
            issue_v = 1'b0;
        end

        // End of a width run: record it, then either stop or start the next width.
        if (finish_v)
        begin
            unique case (stage_reg)
                SIZE_32: res32_next = finish_fail ? RES_FAIL : RES_PASS;
                SIZE_16: res16_next = finish_fail ? RES_FAIL : RES_PASS;
                default: res8_next  = finish_fail ? RES_FAIL : RES_PASS;
            endcase
            if (stage_reg == SIZE_32 || stage_reg == SIZE_16)
            begin
                stage_next   = stage_reg + 2'd1;
                pass_next    = '0;
                reading_next = 1'b0;
                idx_next     = '0;
                issue_v      = 1'b1;
                issue_w      = 1'b1;
            end
            else
            begin
                running_next = 1'b0;
                reading_next = 1'b0;
                done_v       = 1'b1;
            end
        end
    end

    always_comb
    begin
        unique case (stage_next)
            SIZE_32: addr_full = {idx_next, 2'b00};
            SIZE_16: addr_full = {1'b0, idx_next, 1'b0};
            default: addr_full = {2'b00, idx_next};
        endcase
    end

    assign data_next = (issue_v && issue_w) ? pattern_value(pass_next, idx_next, stage_next)
                                             : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg    <= REGION_RESET;
            running_reg   <= 1'b0;
            stage_reg     <= SIZE_32;
            pass_reg      <= '0;
            reading_reg   <= 1'b0;
            idx_reg       <= '0;
            res32_reg     <= RES_NONE;
            res16_reg     <= RES_NONE;
            res8_reg      <= RES_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                region_reg <= cfg_wr_data;
            if (cmd_fire)
            begin
                running_reg <= running_next;
                stage_reg   <= stage_next;
                pass_reg    <= pass_next;
                reading_reg <= reading_next;
                idx_reg     <= idx_next;
                res32_reg   <= res32_next;
                res16_reg   <= res16_next;
                res8_reg    <= res8_next;
            end
            if (cmd_fire)
                out_valid_reg <= 1'b1;
            else if (req.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            req_valid_reg <= issue_v;
            req_write_reg <= issue_v && issue_w;
            req_size_reg  <= issue_v ? stage_next : SIZE_32;
            req_addr_reg  <= issue_v ? addr_full[ADDR_W-1:0] : '0;
            req_data_reg  <= data_next;
            done_reg      <= done_v;
            out_res32_reg <= res32_next;
            out_res16_reg <= res16_next;
            out_res8_reg  <= res8_next;
        end
    end

    assign req.valid         = out_valid_reg;
    assign req.req_valid     = req_valid_reg;
    assign req.req_write     = req_write_reg;
    assign req.req_size      = req_size_reg;
    assign req.req_addr      = req_addr_reg;
    assign req.req_data      = req_data_reg;
    assign req.done_res      = done_reg;
    assign req.result_word32 = out_res32_reg;
    assign req.result_half16 = out_res16_reg;
    assign req.result_byte8  = out_res8_reg;

    // The read phase only exists inside a running test.
    assert property (@(posedge clk) disable iff (!rst_n)
        reading_reg |-> running_reg)
        else $error("read phase active while no test is running");

    // A finishing word carries no request and reports all three widths.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |->
            (!req_valid_reg && out_res32_reg != RES_NONE &&
             out_res16_reg != RES_NONE && out_res8_reg != RES_NONE))
        else $error("done word with a request or an unfinished width");

    // Read requests never carry write data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && req_valid_reg && !req_write_reg) |-> (req_data_reg == '0))
        else $error("read request with nonzero data");

    // A start command yields a 32-bit write to offset zero in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && cmd.op == OP_START) |=>
            (out_valid_reg && req_valid_reg && req_write_reg &&
             req_size_reg == SIZE_32 && req_addr_reg == '0 && running_reg))
        else $error("start did not issue the first write");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the memory pattern test sequencer. It plays the
// memory: it answers write requests with acknowledges and read requests with
// the pattern value, corrupted now and then. A directed table covers the
// corner cases. A random part follows, with short test regions, noise words,
// restarts and region changes mid-run. Every request word is checked against
// a typed row's word, or else a cycle-free model of the sequencing state.
// ============================================================================
module tb_top;
    import mpts_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 400;
    localparam int IDLE_PCT     = 17;

    // The command channel has no name for its fourth code; the block ignores it.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic              req_valid;
        logic              req_write;
        logic [SIZE_W-1:0] req_size;
        logic [ADDR_W-1:0] req_addr;
        logic [DATA_W-1:0] req_data;
        logic              done_res;
        logic [RES_W-1:0]  result_word32;
        logic [RES_W-1:0]  result_half16;
        logic [RES_W-1:0]  result_byte8;
    } req_word_t;

    typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] data;
        bit                typed;
        req_word_t         want;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [REGION_W-1:0] cfg_wr_data;

    mpts_cmd_if cmd_ch ();
    mpts_req_if req_ch ();

    memory_pattern_test_sequencer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd_ch),
        .req         (req_ch)
    );

    // Model of the sequencing state.
    logic [REGION_W-1:0] seq_region;
    logic                seq_running;
    logic [SIZE_W-1:0]   seq_stage;
    logic [PASS_W-1:0]   seq_pass;
    logic                seq_reading;
    logic [INDEX_W-1:0]  seq_index;
    logic [RES_W-1:0]    seq_result [3];

    req_word_t expected_q [$];
    dir_row_t  dir_rows [$];

    int  error_count;
    int  words_sent;
    int  words_checked;
    int  random_words;
    int  tests_done;
    int  runs_passed;
    int  runs_failed;
    int  cycle_count;
    bit  no_idle;

    always #10 clk = ~clk;

    function automatic logic [DATA_W-1:0] width_mask(input logic [SIZE_W-1:0] stage);
        logic [DATA_W-1:0] m;
        case (stage)
            SIZE_32: m = '1;
            SIZE_16: m = 32'h0000_ffff;
            default: m = 32'h0000_00ff;
        endcase
        return m;
    endfunction

    function automatic logic [DATA_W-1:0] pass_pattern(input logic [PASS_W-1:0] pass,
                                                       input logic [INDEX_W-1:0] idx,
                                                       input logic [SIZE_W-1:0] stage);
        logic [DATA_W-1:0] v;
        case (pass)
            3'd0:    v = idx[0] ? {4{8'ha5}} : {4{8'h5a}};
            3'd1:    v = idx[0] ? {4{8'h3c}} : {4{8'hc3}};
            3'd2:    v = {4{8'h55}};
            3'd3:    v = {4{8'haa}};
            3'd4:    v = DATA_W'(idx);
            3'd5:    v = {4{8'h33}};
            3'd6:    v = {4{8'hcc}};
            default: v = {4{8'h77}};
        endcase
        return v & width_mask(stage);
    endfunction

    // Elements in the region at the current width; zero and oversized regions clamp.
    function automatic logic [INDEX_W-1:0] elem_count();
        logic [INDEX_W-1:0] n;
        n = INDEX_W'(seq_region);
        if (n == '0)
            n = INDEX_W'(1);
        if (n > INDEX_W'(REGION_MAX))
            n = INDEX_W'(REGION_MAX);
        return n << seq_stage;
    endfunction

    function automatic req_word_t request_word(input logic wr);
        req_word_t   w;
        logic [63:0] byte_addr;
        w = '0;
        byte_addr = 64'(seq_index) << (2 - seq_stage);
        w.req_valid = 1'b1;
        w.req_write = wr;
        w.req_size  = seq_stage;
        w.req_addr  = byte_addr[ADDR_W-1:0];
        w.req_data  = wr ? pass_pattern(seq_pass, seq_index, seq_stage) : '0;
        return w;
    endfunction

    function automatic req_word_t start_width();
        seq_pass    = '0;
        seq_reading = 1'b0;
        seq_index   = '0;
        return request_word(1'b1);
    endfunction

    function automatic req_word_t end_width(input logic failed);
        req_word_t w;
        w = '0;
        seq_result[seq_stage] = failed ? RES_FAIL : RES_PASS;
        if (failed)
            runs_failed++;
        else
            runs_passed++;
        if (seq_stage == SIZE_8)
        begin
            seq_running = 1'b0;
            seq_reading = 1'b0;
            w.done_res  = 1'b1;
            tests_done++;
        end
        else
        begin
            seq_stage = seq_stage + 1'b1;
            w = start_width();
        end
        return w;
    endfunction

    function automatic req_word_t predict_request(input logic [OP_W-1:0] op,
                                                  input logic [DATA_W-1:0] rdata);
        req_word_t w;
        w = '0;
        if (op == OP_START)
        begin
            seq_running = 1'b1;
            seq_stage   = SIZE_32;
            foreach (seq_result[i])
                seq_result[i] = RES_NONE;
            w = start_width();
        end
        else if (op == OP_WR_ACK && seq_running && !seq_reading)
        begin
            seq_index = seq_index + 1'b1;
            if (seq_index >= elem_count())
            begin
                seq_reading = 1'b1;
                seq_index   = '0;
                w = request_word(1'b0);
            end
            else
            begin
                w = request_word(1'b1);
            end
        end
        else if (op == OP_RD_DATA && seq_running && seq_reading)
        begin
            if ((rdata & width_mask(seq_stage)) != pass_pattern(seq_pass, seq_index, seq_stage))
            begin
                w = end_width(1'b1);
            end
            else
            begin
                seq_index = seq_index + 1'b1;
                if (seq_index < elem_count())
                begin
                    w = request_word(1'b0);
                end
                else if (seq_pass == LAST_PASS)
                begin
                    w = end_width(1'b0);
                end
                else
                begin
                    seq_pass    = seq_pass + 1'b1;
                    seq_reading = 1'b0;
                    seq_index   = '0;
                    w = request_word(1'b1);
                end
            end
        end
        w.result_word32 = seq_result[SIZE_32];
        w.result_half16 = seq_result[SIZE_16];
        w.result_byte8  = seq_result[SIZE_8];
        return w;
    endfunction

    function automatic req_word_t make_word(input logic valid, input logic wr,
                                            input logic [SIZE_W-1:0] size,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [DATA_W-1:0] data,
                                            input logic done,
                                            input logic [RES_W-1:0] r32,
                                            input logic [RES_W-1:0] r16,
                                            input logic [RES_W-1:0] r8);
        req_word_t w;
        w.req_valid     = valid;
        w.req_write     = wr;
        w.req_size      = size;
        w.req_addr      = addr;
        w.req_data      = data;
        w.done_res      = done;
        w.result_word32 = r32;
        w.result_half16 = r16;
        w.result_byte8  = r8;
        return w;
    endfunction

    function automatic void row_typed(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data,
                                      input req_word_t want);
        dir_rows.push_back('{ROW_CMD, op, data, 1'b1, want});
    endfunction

    function automatic void row_checked(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data);
        dir_rows.push_back('{ROW_CMD, op, data, 1'b0, '0});
    endfunction

    function automatic void row_region(input logic [REGION_W-1:0] value);
        dir_rows.push_back('{ROW_CFG, OP_START, DATA_W'(value), 1'b0, '0});
    endfunction

    // An op that the block ignores in its present state.
    function automatic logic [OP_W-1:0] stray_op();
        logic [OP_W-1:0] op;
        if ($urandom_range(0, 2) == 0)
            op = OP_UNUSED;
        else if (!seq_running)
            op = $urandom_range(0, 1) ? OP_WR_ACK : OP_RD_DATA;
        else
            op = seq_reading ? OP_WR_ACK : OP_RD_DATA;
        return op;
    endfunction

    function automatic string word_text(input req_word_t w);
        return $sformatf("v=%0d wr=%0d size=%0d addr=%07h data=%08h done=%0d res=%0d/%0d/%0d",
                         w.req_valid, w.req_write, w.req_size, w.req_addr, w.req_data,
                         w.done_res, w.result_word32, w.result_half16, w.result_byte8);
    endfunction

    task automatic send_word(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data,
                             input bit typed, input req_word_t want, output bit acted);
        req_word_t w;
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.op        <= op;
        cmd_ch.read_data <= data;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        w = predict_request(op, data);
        expected_q.push_back(typed ? want : w);
        words_sent++;
        acted = w.req_valid || w.done_res;
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_region(input logic [REGION_W-1:0] value);
        hold_until_drained();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        seq_region = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    always @(negedge clk)
        req_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge clk)
    begin : check_requests
        req_word_t got;
        req_word_t want;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            got.req_valid     = req_ch.req_valid;
            got.req_write     = req_ch.req_write;
            got.req_size      = req_ch.req_size;
            got.req_addr      = req_ch.req_addr;
            got.req_data      = req_ch.req_data;
            got.done_res      = req_ch.done_res;
            got.result_word32 = req_ch.result_word32;
            got.result_half16 = req_ch.result_half16;
            got.result_byte8  = req_ch.result_byte8;
            if (expected_q.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("ERROR: unexpected request word: %s", word_text(got));
            end
            else
            begin
                want = expected_q.pop_front();
                words_checked++;
                if (got !== want)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("ERROR: request word %0d\n  expected %s\n  actual   %s",
                                 words_checked, word_text(want), word_text(got));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d words still expected",
                     cycle_count, expected_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [REGION_W-1:0] region;
        logic [OP_W-1:0]     op;
        logic [DATA_W-1:0]   data;
        int                  pick;
        int                  steps;
        bit                  big;
        bit                  clean;
        bit                  acted;

        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.op        = OP_START;
        cmd_ch.read_data = '0;
        req_ch.ready     = 1'b0;
        no_idle          = 1'b0;
        seq_region       = REGION_RESET;
        seq_running      = 1'b0;
        seq_stage        = SIZE_32;
        seq_pass         = '0;
        seq_reading      = 1'b0;
        seq_index        = '0;
        foreach (seq_result[i])
            seq_result[i] = RES_NONE;

        // Out-of-place ops while idle, then a start at the reset region size.
        row_typed(OP_WR_ACK, 32'h0, '0);
        row_typed(OP_RD_DATA, 32'hffff_ffff, '0);
        row_typed(OP_UNUSED, 32'hffff_ffff, '0);
        row_typed(OP_START, 32'h0, make_word(1'b1, 1'b1, SIZE_32, '0, 32'h5a5a_5a5a, 1'b0,
                                             RES_NONE, RES_NONE, RES_NONE));
        row_typed(OP_WR_ACK, 32'h0, make_word(1'b1, 1'b1, SIZE_32, 26'd4, 32'ha5a5_a5a5, 1'b0,
                                              RES_NONE, RES_NONE, RES_NONE));
        row_typed(OP_RD_DATA, 32'h5a5a_5a5a, '0);
        // Shrinking the region below the index ends the write phase at the next ack.
        row_region(25'd0);
        row_typed(OP_WR_ACK, 32'h0, make_word(1'b1, 1'b0, SIZE_32, '0, '0, 1'b0,
                                              RES_NONE, RES_NONE, RES_NONE));
        row_typed(OP_WR_ACK, 32'h0, '0);
        row_typed(OP_UNUSED, 32'h0, '0);
        row_typed(OP_RD_DATA, 32'h5a5a_5a5a, make_word(1'b1, 1'b1, SIZE_32, '0, 32'hc3c3_c3c3,
                                                       1'b0, RES_NONE, RES_NONE, RES_NONE));
        row_typed(OP_START, 32'h0, make_word(1'b1, 1'b1, SIZE_32, '0, 32'h5a5a_5a5a, 1'b0,
                                             RES_NONE, RES_NONE, RES_NONE));
        row_typed(OP_WR_ACK, 32'h0, make_word(1'b1, 1'b0, SIZE_32, '0, '0, 1'b0,
                                              RES_NONE, RES_NONE, RES_NONE));
        row_typed(OP_RD_DATA, 32'h0, make_word(1'b1, 1'b1, SIZE_16, '0, 32'h5a5a, 1'b0,
                                               RES_FAIL, RES_NONE, RES_NONE));
        row_region(25'h1ff_ffff);
        row_typed(OP_WR_ACK, 32'h0, make_word(1'b1, 1'b1, SIZE_16, 26'd2, 32'ha5a5, 1'b0,
                                              RES_FAIL, RES_NONE, RES_NONE));
        row_region(25'd1);
        row_typed(OP_WR_ACK, 32'h0, make_word(1'b1, 1'b0, SIZE_16, '0, '0, 1'b0,
                                              RES_FAIL, RES_NONE, RES_NONE));
        row_checked(OP_RD_DATA, 32'hffff_5a5a);
        row_typed(OP_RD_DATA, 32'h0000_a5a4, make_word(1'b1, 1'b1, SIZE_8, '0, 32'h5a, 1'b0,
                                                       RES_FAIL, RES_FAIL, RES_NONE));
        row_checked(OP_WR_ACK, 32'h0);
        row_checked(OP_WR_ACK, 32'h0);
        row_checked(OP_WR_ACK, 32'h0);
        row_checked(OP_WR_ACK, 32'h0);
        row_typed(OP_RD_DATA, 32'h5a5a_5a5b, make_word(1'b0, 1'b0, SIZE_32, '0, '0, 1'b1,
                                                       RES_FAIL, RES_FAIL, RES_FAIL));
        row_typed(OP_RD_DATA, 32'h0, make_word(1'b0, 1'b0, SIZE_32, '0, '0, 1'b0,
                                               RES_FAIL, RES_FAIL, RES_FAIL));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_region(REGION_W'(dir_rows[i].data));
            else
                send_word(dir_rows[i].op, dir_rows[i].data, dir_rows[i].typed,
                          dir_rows[i].want, acted);
        end

        // Random tests: mostly tiny regions so that whole tests complete.
        while (random_words < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            big  = 1'b0;
            if (pick < 40)
            begin
                region = 25'd1;
            end
            else if (pick < 55)
            begin
                region = 25'd0;
            end
            else if (pick < 70)
            begin
                region = 25'd2;
            end
            else if (pick < 80)
            begin
                region = REGION_W'($urandom_range(3, 4));
            end
            else
            begin
                big = 1'b1;
                case ($urandom_range(0, 2))
                    0:       region = REGION_MAX;
                    1:       region = '1;
                    default: region = REGION_W'($urandom());
                endcase
            end
            write_region(region);
            clean = bit'($urandom_range(0, 1));
            if ($urandom_range(0, 4) == 0)
                send_word(stray_op(), $urandom(), 1'b0, '0, acted);
            send_word(OP_START, $urandom(), 1'b0, '0, acted);
            random_words++;
            steps = 0;
            while (seq_running && random_words < RANDOM_ITEMS)
            begin
                // A huge region never finishes; cut it down after a few words.
                if (big && steps == 24)
                    write_region(REGION_W'($urandom_range(1, 2)));
                pick = $urandom_range(0, 299);
                if (pick == 0)
                begin
                    op   = OP_START;
                    data = $urandom();
                end
                else if (pick < 16)
                begin
                    op   = stray_op();
                    data = $urandom();
                end
                else if (!seq_reading)
                begin
                    op   = OP_WR_ACK;
                    data = $urandom();
                end
                else
                begin
                    op   = OP_RD_DATA;
                    data = pass_pattern(seq_pass, seq_index, seq_stage)
                         | ($urandom() & ~width_mask(seq_stage));
                    if (!clean && $urandom_range(0, 99) < 3)
                        data = data ^ (32'h1 << $urandom_range(0, (32 >> seq_stage) - 1));
                end
                send_word(op, data, 1'b0, '0, acted);
                if (acted)
                    random_words++;
                steps++;
                no_idle = (random_words >= 120 && random_words < 240);
                if ($urandom_range(0, 199) == 0)
                    hold_until_drained();
            end
        end

        hold_until_drained();
        repeat (5) @(posedge clk);
        $display("Sent %0d command words (%0d active in the random part), checked %0d requests.",
                 words_sent, random_words, words_checked);
        $display("Completed %0d full tests; width runs passed %0d, failed %0d.",
                 tests_done, runs_passed, runs_failed);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
